/* hw/rtl/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hw/rtl/urfld_pkg.sv */
// types and constants for the uart ring buffer pair
`timescale 1ns / 1ps
`default_nettype none
package urfld_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int CNT_W         = 6;
  localparam logic [7:0] EOL_RESET = 8'h0D;

  typedef enum logic [2:0] {
    CMD_TX_WRITE  = 3'd0,
    CMD_TX_DONE   = 3'd1,
    CMD_RX_BYTE   = 3'd2,
    CMD_HOST_READ = 3'd3,
    CMD_RX_FLUSH  = 3'd4,
    CMD_TX_START  = 3'd5
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic       kick;
    logic       irq_on_start;
    logic       clear_line;
  } in_item_t;

  typedef struct packed {
    logic             line_send;
    logic [7:0]       line_byte;
    logic             read_valid;
    logic [7:0]       read_byte;
    logic             tx_accepted;
    logic [CNT_W-1:0] tx_count;
    logic [CNT_W-1:0] rx_count;
    logic             tx_full;
    logic             line_ready;
    logic             tx_busy;
    logic             tx_irq_enabled;
    logic [7:0]       tx_sum;
  } out_item_t;

endpackage
`default_nettype wire

/* hw/rtl/uart_ring_fifo_with_line_detect_unit.sv */
// top level: uart transmit and receive rings with end-of-line detection
//
// channel | ports                              | direction
// --------+------------------------------------+----------
// input   | in_valid, in_ready, in_data        | in
// result  | out_valid, out_ready, out_data     | out
// config  | cfg_valid, cfg_ready, cfg_data     | in
//
// the accept cycle of a word reads both rings at their read pointers; the next
// cycle uses the registered ram data, writes back and loads the result register.
// a new word is taken only in the idle state, once the result register is empty or being drained.
// reset clears pointers, flags and the tx checksum only; ring contents are left as they are.
// cfg_ready is always high; eol_char resets to 0x0d.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module uart_ring_fifo_with_line_detect_unit #(
  parameter int DEPTH = urfld_pkg::DEPTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire urfld_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output urfld_pkg::out_item_t      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [7:0]           cfg_data
);

  localparam int PW  = $clog2(DEPTH);
  localparam int PW1 = PW + 1;
  localparam int CW  = urfld_pkg::CNT_W;
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [PW:0]   DEPTH_X  = PW1'(DEPTH);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW:0] ring_cnt(input logic [PW-1:0] r, input logic [PW-1:0] w);
    if (w >= r) begin
      ring_cnt = {1'b0, w} - {1'b0, r};
    end else begin
      ring_cnt = {1'b0, w} + DEPTH_X - {1'b0, r};
    end
  endfunction

  urfld_pkg::state_t    state_r, state_nxt;
  urfld_pkg::in_item_t  item_r;
  urfld_pkg::out_item_t out_r, res;
  logic                 out_valid_r, out_valid_nxt;

  logic [PW-1:0] tx_rd_r, tx_rd_nxt, tx_wr_r, tx_wr_nxt;
  logic [PW-1:0] rx_rd_r, rx_rd_nxt, rx_wr_r, rx_wr_nxt;
  logic          running_r, running_nxt, irq_en_r, irq_en_nxt, line_r, line_nxt;
  logic [7:0]    sum_r, sum_nxt, eol_r;

  logic       exec;
  logic       tx_we, rx_we;
  logic [7:0] tx_rdata, rx_rdata;
  logic       tx_empty, tx_full, rx_empty;
  logic [PW:0] tx_cnt, rx_cnt;

  urfld_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wr_r),
    .wdata (item_r.data_byte),
    .raddr (tx_rd_r),
    .rdata (tx_rdata)
  );

  urfld_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wr_r),
    .wdata (item_r.data_byte),
    .raddr (rx_rd_r),
    .rdata (rx_rdata)
  );

  // one word in flight at a time, so a write-back always lands before the next read
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      urfld_pkg::ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        if (in_valid && in_ready) begin
          state_nxt = urfld_pkg::ST_EXEC;
        end
      end
      urfld_pkg::ST_EXEC: begin
        state_nxt = urfld_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = urfld_pkg::ST_IDLE;
      end
    endcase
  end

  assign exec     = (state_r == urfld_pkg::ST_EXEC);
  assign tx_empty = (tx_rd_r == tx_wr_r);
  assign tx_full  = (ptr_inc(tx_wr_r) == tx_rd_r);
  assign rx_empty = (rx_rd_r == rx_wr_r);

  always_comb begin
    tx_rd_nxt   = tx_rd_r;
    tx_wr_nxt   = tx_wr_r;
    rx_rd_nxt   = rx_rd_r;
    rx_wr_nxt   = rx_wr_r;
    running_nxt = running_r;
    irq_en_nxt  = irq_en_r;
    line_nxt    = line_r;
    sum_nxt     = sum_r;
    tx_we       = 1'b0;
    rx_we       = 1'b0;
    res         = '0;
    case (item_r.command)
      urfld_pkg::CMD_TX_WRITE: begin
        if (!(tx_full && running_r)) begin
          tx_we           = exec;
          tx_wr_nxt       = ptr_inc(tx_wr_r);
          res.tx_accepted = 1'b1;
          sum_nxt         = sum_r + item_r.data_byte;
          if (tx_full) begin
            // make room by starting the line
            res.line_send = 1'b1;
            res.line_byte = tx_rdata;
            tx_rd_nxt     = ptr_inc(tx_rd_r);
            running_nxt   = 1'b1;
            irq_en_nxt    = 1'b1;
          end else if (!running_r && item_r.kick) begin
            // idle with kick: the oldest byte goes out, or the word just written if the ring was empty
            res.line_send = 1'b1;
            res.line_byte = tx_empty ? item_r.data_byte : tx_rdata;
            tx_rd_nxt     = ptr_inc(tx_rd_r);
            running_nxt   = 1'b1;
            irq_en_nxt    = 1'b1;
          end
        end
      end
      urfld_pkg::CMD_TX_DONE: begin
        if (!tx_empty) begin
          res.line_send = 1'b1;
          res.line_byte = tx_rdata;
          tx_rd_nxt     = ptr_inc(tx_rd_r);
        end else begin
          running_nxt = 1'b0;
          irq_en_nxt  = 1'b0;
        end
      end
      urfld_pkg::CMD_RX_BYTE: begin
        if (eol_r != 8'd0 && eol_r == item_r.data_byte) begin
          line_nxt = 1'b1;
        end
        if (ptr_inc(rx_wr_r) != rx_rd_r) begin
          rx_we     = exec;
          rx_wr_nxt = ptr_inc(rx_wr_r);
        end
      end
      urfld_pkg::CMD_HOST_READ: begin
        if (!rx_empty) begin
          res.read_valid = 1'b1;
          res.read_byte  = rx_rdata;
          rx_rd_nxt      = ptr_inc(rx_rd_r);
        end
        if (item_r.clear_line) begin
          line_nxt = 1'b0;
        end
      end
      urfld_pkg::CMD_RX_FLUSH: begin
        rx_rd_nxt = '0;
        rx_wr_nxt = '0;
        line_nxt  = 1'b0;
      end
      urfld_pkg::CMD_TX_START: begin
        if (!running_r && !tx_empty) begin
          res.line_send = 1'b1;
          res.line_byte = tx_rdata;
          tx_rd_nxt     = ptr_inc(tx_rd_r);
          running_nxt   = 1'b1;
          irq_en_nxt    = item_r.irq_on_start;
        end
      end
      default: begin
      end
    endcase
    tx_cnt             = ring_cnt(tx_rd_nxt, tx_wr_nxt);
    rx_cnt             = ring_cnt(rx_rd_nxt, rx_wr_nxt);
    res.tx_count       = CW'(tx_cnt);
    res.rx_count       = CW'(rx_cnt);
    res.tx_full        = (ptr_inc(tx_wr_nxt) == tx_rd_nxt);
    res.line_ready     = line_nxt;
    res.tx_busy        = running_nxt;
    res.tx_irq_enabled = irq_en_nxt;
    res.tx_sum         = sum_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= urfld_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      tx_rd_r     <= '0;
      tx_wr_r     <= '0;
      rx_rd_r     <= '0;
      rx_wr_r     <= '0;
      running_r   <= 1'b0;
      irq_en_r    <= 1'b0;
      line_r      <= 1'b0;
      sum_r       <= 8'd0;
      eol_r       <= urfld_pkg::EOL_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec) begin
        tx_rd_r   <= tx_rd_nxt;
        tx_wr_r   <= tx_wr_nxt;
        rx_rd_r   <= rx_rd_nxt;
        rx_wr_r   <= rx_wr_nxt;
        running_r <= running_nxt;
        irq_en_r  <= irq_en_nxt;
        line_r    <= line_nxt;
        sum_r     <= sum_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        eol_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (exec) begin
      out_r <= res;
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_RST(a_accept_gives_result, clk, rst_n, in_valid && in_ready |=> ##1 out_valid, "lost")
  `ASSERT_RST(a_no_accept_in_exec, clk, rst_n, exec |-> !in_ready, "accept while busy")
  `ASSERT_RST(a_busy_falls_in_exec, clk, rst_n, $fell(running_r) |-> $past(exec), "stray stop")
  `ASSERT_RST(a_out_held, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")

endmodule
`default_nettype wire

/* hw/rtl/urfld_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module urfld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = urfld_pkg::DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* dv/uart_ring_fifo_with_line_detect_unit_tb.sv */
// testbench for the uart ring buffer pair with end-of-line detection
`timescale 1ns / 1ps
module uart_ring_fifo_with_line_detect_unit_tb;

  localparam int DEPTH = urfld_pkg::DEPTH_DEFAULT;
  // command codes the block treats as no-ops
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  urfld_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  urfld_pkg::out_item_t out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [7:0]           cfg_data = '0;

  uart_ring_fifo_with_line_detect_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the rings and flags
  logic [7:0]  tx_ring [DEPTH];
  logic [7:0]  rx_ring [DEPTH];
  int unsigned tx_rd, tx_wr, rx_rd, rx_wr;
  bit          tx_running, tx_irq, line_seen;
  logic [7:0]  tx_checksum = '0;
  logic [7:0]  eol_byte = urfld_pkg::EOL_RESET;

  urfld_pkg::in_item_t  host_words [$];
  urfld_pkg::out_item_t status_due [$];

  int words_in, results_seen, mismatches;
  int line_sends, host_pops, full_hits, rejects;

  function automatic int unsigned ring_next(input int unsigned p);
    return (p + 1) % DEPTH;
  endfunction

  function automatic int unsigned ring_fill(input int unsigned rd, input int unsigned wr);
    return (wr + DEPTH - rd) % DEPTH;
  endfunction

  function automatic bit tx_ring_full();
    return ring_next(tx_wr) == tx_rd;
  endfunction

  // start the transmitter if idle with data waiting; returns 1 when a byte goes out
  function automatic bit tx_launch(input bit irq, output logic [7:0] b);
    b = '0;
    if (tx_running || tx_rd == tx_wr) return 1'b0;
    b = tx_ring[tx_rd];
    tx_rd = ring_next(tx_rd);
    tx_running = 1'b1;
    tx_irq = irq;
    return 1'b1;
  endfunction

  task automatic step_rings(input urfld_pkg::in_item_t w);
    urfld_pkg::out_item_t s;
    logic [7:0] sent_b;
    logic [7:0] read_b;
    bit         sent;
    bit         popped;
    bit         acc;
    s = '0;
    sent = 1'b0;
    popped = 1'b0;
    acc = 1'b0;
    sent_b = '0;
    read_b = '0;
    case (w.command)
      urfld_pkg::CMD_TX_WRITE: begin
        if (tx_ring_full()) full_hits++;
        if (tx_ring_full() && tx_running) begin
          rejects++;
        end else begin
          // full and idle: make room by sending the oldest byte first
          if (tx_ring_full()) sent = tx_launch(1'b1, sent_b);
          tx_ring[tx_wr] = w.data_byte;
          tx_wr = ring_next(tx_wr);
          acc = 1'b1;
          if (!tx_running && w.kick) sent = tx_launch(1'b1, sent_b);
          tx_checksum = tx_checksum + w.data_byte;
        end
      end
      urfld_pkg::CMD_TX_DONE: begin
        if (tx_rd != tx_wr) begin
          sent_b = tx_ring[tx_rd];
          tx_rd = ring_next(tx_rd);
          sent = 1'b1;
        end else begin
          tx_running = 1'b0;
          tx_irq = 1'b0;
        end
      end
      urfld_pkg::CMD_RX_BYTE: begin
        if (eol_byte != 8'h00 && eol_byte == w.data_byte) line_seen = 1'b1;
        if (ring_next(rx_wr) != rx_rd) begin
          rx_ring[rx_wr] = w.data_byte;
          rx_wr = ring_next(rx_wr);
        end
      end
      urfld_pkg::CMD_HOST_READ: begin
        if (rx_rd != rx_wr) begin
          read_b = rx_ring[rx_rd];
          rx_rd = ring_next(rx_rd);
          popped = 1'b1;
        end
        if (w.clear_line) line_seen = 1'b0;
      end
      urfld_pkg::CMD_RX_FLUSH: begin
        rx_rd = 0;
        rx_wr = 0;
        line_seen = 1'b0;
      end
      urfld_pkg::CMD_TX_START: sent = tx_launch(w.irq_on_start, sent_b);
      default: ;
    endcase
    if (sent) line_sends++;
    if (popped) host_pops++;
    s.line_send      = sent;
    s.line_byte      = sent ? sent_b : 8'h00;
    s.read_valid     = popped;
    s.read_byte      = popped ? read_b : 8'h00;
    s.tx_accepted    = acc;
    s.tx_count       = urfld_pkg::CNT_W'(ring_fill(tx_rd, tx_wr));
    s.rx_count       = urfld_pkg::CNT_W'(ring_fill(rx_rd, rx_wr));
    s.tx_full        = tx_ring_full();
    s.line_ready     = line_seen;
    s.tx_busy        = tx_running;
    s.tx_irq_enabled = tx_irq;
    s.tx_sum         = tx_checksum;
    status_due.push_back(s);
    words_in++;
  endtask

  task automatic cmp_field(input string nm, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch at result %0d, %s: expected %0h, got %0h",
                 results_seen, nm, want, got);
    end
  endtask

  task automatic check_status(input urfld_pkg::out_item_t got);
    urfld_pkg::out_item_t want;
    if (status_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result with no word pending: %h", got);
      return;
    end
    want = status_due.pop_front();
    results_seen++;
    cmp_field("line_send", 8'(want.line_send), 8'(got.line_send));
    cmp_field("line_byte", want.line_byte, got.line_byte);
    cmp_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
    cmp_field("read_byte", want.read_byte, got.read_byte);
    cmp_field("tx_accepted", 8'(want.tx_accepted), 8'(got.tx_accepted));
    cmp_field("tx_count", 8'(want.tx_count), 8'(got.tx_count));
    cmp_field("rx_count", 8'(want.rx_count), 8'(got.rx_count));
    cmp_field("tx_full", 8'(want.tx_full), 8'(got.tx_full));
    cmp_field("line_ready", 8'(want.line_ready), 8'(got.line_ready));
    cmp_field("tx_busy", 8'(want.tx_busy), 8'(got.tx_busy));
    cmp_field("tx_irq_enabled", 8'(want.tx_irq_enabled), 8'(got.tx_irq_enabled));
    cmp_field("tx_sum", want.tx_sum, got.tx_sum);
  endtask

  // driver: one word at a time from the queue, random gap after each
  int in_gap = 0;
  bit in_calm = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) step_rings(in_data);
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (host_words.size() != 0) begin
        in_data <= host_words.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 29) == 0) in_calm = !in_calm;
        in_gap <= in_calm ? 0 : $urandom_range(0, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each result, then stalls for a random number of cycles
  int out_stall = 0;
  bit out_calm = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_status(out_data);
        if ($urandom_range(0, 29) == 0) out_calm = !out_calm;
        out_stall = out_calm ? 0 : $urandom_range(0, 9);
      end
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_word(input logic [2:0] cmd, input logic [7:0] d, input bit k,
                           input bit irq, input bit clr);
    urfld_pkg::in_item_t w;
    w.command = cmd;
    w.data_byte = d;
    w.kick = k;
    w.irq_on_start = irq;
    w.clear_line = clr;
    host_words.push_back(w);
  endtask

  function automatic logic [7:0] rx_pick(input logic [7:0] eol);
    case ($urandom_range(0, 4))
      0: return eol;
      1: return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // runs of writes, drains, receives and reads with some noise in between;
  // long runs push both rings through their full states
  task automatic queue_traffic(input int n, input logic [7:0] eol);
    int left;
    int len;
    int kind;
    logic [7:0] d;
    bit k;
    bit irq;
    bit clr;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 72) : $urandom_range(1, 8);
      if (kind >= 6 && kind <= 7) len = 1;
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        d = 8'($urandom_range(0, 255));
        k = 1'($urandom_range(0, 1));
        irq = 1'($urandom_range(0, 1));
        clr = 1'($urandom_range(0, 1));
        case (kind)
          0, 1: push_word(urfld_pkg::CMD_TX_WRITE, d, $urandom_range(0, 5) == 0, irq, clr);
          2: push_word(urfld_pkg::CMD_TX_DONE, d, k, irq, clr);
          3, 4: push_word(urfld_pkg::CMD_RX_BYTE, rx_pick(eol), k, irq, clr);
          5: push_word(urfld_pkg::CMD_HOST_READ, d, k, irq, clr);
          6: push_word(urfld_pkg::CMD_TX_START, d, k, irq, clr);
          7: push_word(urfld_pkg::CMD_RX_FLUSH, d, k, irq, clr);
          default: push_word(3'($urandom_range(0, 7)), d, k, irq, clr);
        endcase
      end
      left -= len;
    end
  endtask

  task automatic wait_drained();
    while (host_words.size() != 0 || in_valid || status_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_eol(input logic [7:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    eol_byte = v;
    cfg_valid <= 1'b0;
  endtask

  logic [7:0] eol_plan [3];

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // start and stop of the transmitter, kick and start while busy
    push_word(urfld_pkg::CMD_TX_START, 8'h00, 1'b0, 1'b1, 1'b0);
    push_word(urfld_pkg::CMD_TX_DONE, 8'h00, 1'b0, 1'b0, 1'b0);
    push_word(urfld_pkg::CMD_TX_WRITE, 8'h00, 1'b0, 1'b0, 1'b0);
    push_word(urfld_pkg::CMD_TX_WRITE, 8'hFF, 1'b1, 1'b0, 1'b0);
    push_word(urfld_pkg::CMD_TX_WRITE, 8'h5A, 1'b1, 1'b0, 1'b0);
    push_word(urfld_pkg::CMD_TX_START, 8'h00, 1'b0, 1'b0, 1'b0);
    push_word(urfld_pkg::CMD_TX_DONE, 8'h00, 1'b0, 1'b0, 1'b0);
    push_word(urfld_pkg::CMD_TX_DONE, 8'h00, 1'b0, 1'b0, 1'b0);
    push_word(urfld_pkg::CMD_TX_DONE, 8'h00, 1'b0, 1'b0, 1'b0);
    push_word(urfld_pkg::CMD_TX_WRITE, 8'h81, 1'b0, 1'b0, 1'b0);
    push_word(urfld_pkg::CMD_TX_START, 8'h00, 1'b0, 1'b0, 1'b0);
    push_word(urfld_pkg::CMD_TX_DONE, 8'h00, 1'b0, 1'b0, 1'b0);
    push_word(urfld_pkg::CMD_TX_DONE, 8'h00, 1'b0, 1'b0, 1'b0);
    // receive side: end-of-line byte, extremes, reads with and without clear
    push_word(urfld_pkg::CMD_RX_BYTE, urfld_pkg::EOL_RESET, 1'b0, 1'b0, 1'b0);
    push_word(urfld_pkg::CMD_RX_BYTE, 8'h00, 1'b0, 1'b0, 1'b0);
    push_word(urfld_pkg::CMD_RX_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0);
    push_word(urfld_pkg::CMD_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b0);
    push_word(urfld_pkg::CMD_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b1);
    push_word(urfld_pkg::CMD_RX_BYTE, urfld_pkg::EOL_RESET, 1'b0, 1'b0, 1'b0);
    push_word(urfld_pkg::CMD_RX_FLUSH, 8'h00, 1'b0, 1'b0, 1'b0);
    push_word(urfld_pkg::CMD_HOST_READ, 8'h00, 1'b0, 1'b0, 1'b1);
    // unused command codes with every field set
    push_word(CMD_SPARE_A, 8'hFF, 1'b1, 1'b1, 1'b1);
    push_word(CMD_SPARE_B, 8'hFF, 1'b1, 1'b1, 1'b1);
    // tx done pops even while the transmitter is idle
    push_word(urfld_pkg::CMD_TX_WRITE, 8'h7F, 1'b0, 1'b0, 1'b0);
    push_word(urfld_pkg::CMD_TX_DONE, 8'h00, 1'b0, 1'b0, 1'b0);
    push_word(urfld_pkg::CMD_TX_DONE, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_traffic(160, urfld_pkg::EOL_RESET);
    wait_drained();

    // detection off, then the top value, then a random value in between
    eol_plan[0] = 8'h00;
    eol_plan[1] = 8'hFF;
    eol_plan[2] = 8'($urandom_range(1, 254));
    foreach (eol_plan[p]) begin
      write_eol(eol_plan[p]);
      queue_traffic(160, eol_plan[p]);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("%0d words checked over four end-of-line settings: %0d line sends, %0d host pops",
             results_seen, line_sends, host_pops);
    $display("tx ring found full %0d times, %0d writes rejected, %0d mismatches",
             full_hits, rejects, mismatches);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* uart_ring_fifo_with_line_detect_unit.f */
+incdir+hw/rtl
hw/rtl/urfld_pkg.sv
hw/rtl/urfld_ram.sv
hw/rtl/uart_ring_fifo_with_line_detect_unit.sv
dv/uart_ring_fifo_with_line_detect_unit_tb.sv
